@@ hdl/foel_pkg.sv @@
package foel_pkg;

  localparam int unsigned DirectExtents = 16;
  localparam int unsigned SmallDirectExtents = 8;
  localparam int unsigned FanoutLog2 = 11;
  localparam int unsigned DeviceBlockShift = 10;

  localparam int unsigned OffW = 64;
  localparam int unsigned BnW = OffW - 1 - DeviceBlockShift;
  localparam int unsigned UblkW = 25;
  localparam int unsigned QuoW = BnW;
  localparam int unsigned IdxW = 11;
  localparam int unsigned SlotW = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;

  typedef enum logic [CfgIdxW-1:0] {
    RegDataLargeKb  = 3'd0,
    RegDataSmallSh  = 3'd1,
    RegDataLargeSh  = 3'd2,
    RegMetaLargeKb  = 3'd3,
    RegMetaSmallSh  = 3'd4,
    RegMetaLargeSh  = 3'd5,
    RegLegacyBug    = 3'd6,
    RegUnused       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [OffW-1:0] byte_offset;
    logic            is_meta;
    logic            large_only;
    logic [7:0]      stripe_width;
  } req_t;

  typedef struct packed {
    logic             too_big;
    logic [SlotW-1:0] extent_slot;
    logic             device_class;
    logic             block_kind;
    logic [4:0]       extents_left;
    logic [IdxW-1:0]  level0_index;
    logic [IdxW-1:0]  level1_index;
    logic [IdxW-1:0]  level2_index;
  } rsp_t;

  // Per-item context traveling along the divider chain.
  typedef struct packed {
    logic            neg;
    logic            is_meta;
    logic            large_only;
    logic            use_shift;
    logic            direct;
    logic            small_unit;
    logic [4:0]      sh_s;
    logic [4:0]      sh_l;
    logic [BnW-1:0]  bn;
    logic [BnW-1:0]  rem_base;
    logic [UblkW-1:0] ublks;
    logic            legacy;
  } ctx_t;

  typedef struct packed {
    logic [BnW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_t;

endpackage

@@ hdl/foel_if.sv @@
interface foel_req_if;
  logic          valid;
  logic          ready;
  foel_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface foel_rsp_if;
  logic          valid;
  logic          ready;
  foel_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface foel_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [foel_pkg::CfgIdxW-1:0]   index;
  logic [foel_pkg::CfgDataW-1:0]  wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/file_offset_extent_locator.sv @@
// Channel | Dir | Payload
// req     | in  | byte_offset, is_meta, large_only, stripe_width
// rsp     | out | too_big, extent_slot, device_class, block_kind, extents_left, levelN_index
// cfg     | in  | index, wdata
// One request enters per cycle; each passes the input register, the division
// cells (one quotient bit per cell) and the output register. The whole chain
// advances only when the output register is free or being taken, so a stalled
// response freezes it. Reset clears all valid bits and loads the register defaults.
module file_offset_extent_locator (
  input  logic     clk_i,
  input  logic     rst_ni,
  foel_req_if.sink req,
  foel_rsp_if.source rsp,
  foel_cfg_if.sink cfg
);
  localparam int unsigned N = foel_pkg::QuoW;

  logic            en;
  logic            vld [N+1];
  foel_pkg::ctx_t  ctx [N+1];
  foel_pkg::div_t  dv [N+1];
  foel_pkg::ctx_t  ctx0_d, ctx0_q;
  logic            vld0_q;
  foel_pkg::rsp_t  rsp_d;

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  foel_front u_front (.clk_i, .rst_ni, .cfg(cfg), .req_i(req.data), .ctx_o(ctx0_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld0_q <= 1'b0;
    else if (en) vld0_q <= req.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) ctx0_q <= ctx0_d;
  end

  assign vld[0] = vld0_q;
  assign ctx[0] = ctx0_q;
  assign dv[0] = '{rem: ctx0_q.rem_base, quo: '0};

  for (genvar g = 0; g < N; g++) begin : g_cell
    foel_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .bit_i(6'(N - 1 - g)),
      .vld_i(vld[g]), .ctx_i(ctx[g]), .div_i(dv[g]),
      .vld_o(vld[g+1]), .ctx_o(ctx[g+1]), .div_o(dv[g+1])
    );
  end

  foel_back u_back (.ctx_i(ctx[N]), .div_i(dv[N]), .rsp_o(rsp_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp.valid <= 1'b0;
    else if (en) rsp.valid <= vld[N];
  end

  always_ff @(posedge clk_i) begin
    if (en) rsp.data <= rsp_d;
  end
endmodule

@@ hdl/foel_div_cell.sv @@
// One restoring-division cell: settles one quotient bit per item and hands on.
module foel_div_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [5:0]             bit_i,
  input  logic                   vld_i,
  input  foel_pkg::ctx_t         ctx_i,
  input  foel_pkg::div_t         div_i,
  output logic                   vld_o,
  output foel_pkg::ctx_t         ctx_o,
  output foel_pkg::div_t         div_o
);
  logic [foel_pkg::BnW+foel_pkg::UblkW-1:0] shifted;
  logic                                     fits;
  foel_pkg::div_t                           div_d;

  always_comb begin
    shifted = {{foel_pkg::BnW{1'b0}}, ctx_i.ublks} << bit_i;
    fits = ({{foel_pkg::UblkW{1'b0}}, div_i.rem} >= shifted);
    div_d = div_i;
    if (fits) begin
      div_d.rem = div_i.rem - shifted[foel_pkg::BnW-1:0];
      div_d.quo[bit_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_o <= ctx_i;
      div_o <= div_d;
    end
  end
endmodule

@@ hdl/foel_front.sv @@
// Register bank and first stage: class select, direct boundary, remainder setup.
module foel_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  foel_cfg_if.sink          cfg,
  input  foel_pkg::req_t    req_i,
  output foel_pkg::ctx_t    ctx_o
);
  logic [16:0] dkb_q, mkb_q;
  logic [4:0]  dss_q, dls_q, mss_q, mls_q;
  logic        leg_q;
  logic [16:0] kb;
  logic [4:0]  sh_s, sh_l;
  logic [24:0] ublks;
  logic        use_shift;
  logic [foel_pkg::BnW-1:0] bn, dir, sboundary;
  logic [79:0] dwide;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dkb_q <= 17'd64;
      dss_q <= 5'd2;
      dls_q <= 5'd6;
      mkb_q <= 17'd16;
      mss_q <= 5'd2;
      mls_q <= 5'd4;
      leg_q <= 1'b0;
    end else if (cfg.valid) begin
      unique case (foel_pkg::cfg_reg_e'(cfg.index))
        foel_pkg::RegDataLargeKb: dkb_q <= cfg.wdata;
        foel_pkg::RegDataSmallSh: dss_q <= cfg.wdata[4:0];
        foel_pkg::RegDataLargeSh: dls_q <= cfg.wdata[4:0];
        foel_pkg::RegMetaLargeKb: mkb_q <= cfg.wdata;
        foel_pkg::RegMetaSmallSh: mss_q <= cfg.wdata[4:0];
        foel_pkg::RegMetaLargeSh: mls_q <= cfg.wdata[4:0];
        foel_pkg::RegLegacyBug:   leg_q <= cfg.wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kb = req_i.is_meta ? mkb_q : dkb_q;
    sh_s = req_i.is_meta ? mss_q : dss_q;
    sh_l = req_i.is_meta ? mls_q : dls_q;
    if (kb == 17'd0) kb = 17'd1;
    ublks = (req_i.stripe_width > 8'd1) ? 25'(kb) * 25'(req_i.stripe_width) : {8'd0, kb};
    use_shift = (sh_l != 5'd0) && (req_i.stripe_width == 8'd1);
    bn = req_i.byte_offset[foel_pkg::OffW-2:foel_pkg::DeviceBlockShift];
    sboundary = foel_pkg::BnW'(80'(foel_pkg::SmallDirectExtents) << sh_s);
    if (use_shift) begin
      if (req_i.large_only) dwide = 80'(foel_pkg::DirectExtents) << sh_l;
      else dwide = (80'(foel_pkg::SmallDirectExtents) << sh_s)
                 + (80'(foel_pkg::DirectExtents - foel_pkg::SmallDirectExtents) << sh_l);
    end else begin
      dwide = 80'(ublks) * 80'(foel_pkg::DirectExtents);
    end
    dir = (dwide[79:foel_pkg::BnW] != '0) ? '1 : dwide[foel_pkg::BnW-1:0];
    ctx_o.neg = req_i.byte_offset[foel_pkg::OffW-1];
    ctx_o.is_meta = req_i.is_meta;
    ctx_o.large_only = req_i.large_only;
    ctx_o.use_shift = use_shift;
    ctx_o.direct = (dwide[79:foel_pkg::BnW] != '0) || (bn < dir);
    ctx_o.small_unit = !req_i.large_only && (bn < sboundary);
    ctx_o.sh_s = sh_s;
    ctx_o.sh_l = sh_l;
    ctx_o.bn = bn;
    ctx_o.ublks = ublks;
    ctx_o.legacy = leg_q;
    if (ctx_o.direct) begin
      ctx_o.rem_base = req_i.large_only ? bn : bn - sboundary;
    end else begin
      ctx_o.rem_base = bn - dir;
    end
  end
endmodule

@@ hdl/foel_back.sv @@
// Last stage: turns the unit number into slot, kind, extents left and indirect indices, or flags too_big.
module foel_back (
  input  foel_pkg::ctx_t  ctx_i,
  input  foel_pkg::div_t  div_i,
  output foel_pkg::rsp_t  rsp_o
);
  logic [foel_pkg::BnW-1:0] u, t1, t2, slot;
  logic [foel_pkg::IdxW:0]  k1;
  logic                     err;
  localparam logic [foel_pkg::BnW-1:0] Fan = foel_pkg::BnW'(1) << foel_pkg::FanoutLog2;
  localparam logic [foel_pkg::BnW-1:0] Last = foel_pkg::BnW'(foel_pkg::DirectExtents - 1);

  always_comb begin
    u = (ctx_i.use_shift || (ctx_i.direct && !ctx_i.large_only))
      ? ctx_i.rem_base >> ctx_i.sh_l : div_i.quo;
    rsp_o = '0;
    err = ctx_i.neg;
    rsp_o.device_class = ctx_i.is_meta;
    rsp_o.block_kind = 1'b1;
    t1 = (u >> foel_pkg::FanoutLog2) - 1'b1;
    t2 = (t1 >> foel_pkg::FanoutLog2) - 1'b1;
    k1 = {1'b0, t1[foel_pkg::IdxW-1:0]} + (foel_pkg::IdxW+1)'(ctx_i.legacy);
    if (ctx_i.direct) begin
      if (ctx_i.small_unit) begin
        slot = ctx_i.bn >> ctx_i.sh_s;
        rsp_o.block_kind = 1'b0;
        rsp_o.extents_left = 5'(foel_pkg::SmallDirectExtents - slot);
      end else begin
        slot = ctx_i.large_only ? u : u + foel_pkg::BnW'(foel_pkg::SmallDirectExtents);
        if (!ctx_i.large_only && u > Last) slot = Last;
        if (slot > Last) slot = Last;
        rsp_o.extents_left = 5'(foel_pkg::DirectExtents - slot);
      end
    end else if (u < Fan) begin
      slot = foel_pkg::BnW'(foel_pkg::DirectExtents);
      rsp_o.level0_index = u[foel_pkg::IdxW-1:0];
    end else if (t1 < Fan) begin
      slot = foel_pkg::BnW'(foel_pkg::DirectExtents + 1);
      rsp_o.level0_index = t1[foel_pkg::IdxW-1:0];
      rsp_o.level1_index = u[foel_pkg::IdxW-1:0];
    end else begin
      slot = foel_pkg::BnW'(foel_pkg::DirectExtents + 2);
      if (k1[foel_pkg::IdxW] || t2 >= Fan) err = 1'b1;
      rsp_o.level0_index = t2[foel_pkg::IdxW-1:0];
      rsp_o.level1_index = k1[foel_pkg::IdxW-1:0];
      rsp_o.level2_index = u[foel_pkg::IdxW-1:0];
    end
    rsp_o.extent_slot = slot[foel_pkg::SlotW-1:0];
    if (err) begin
      rsp_o = '0;
      rsp_o.too_big = 1'b1;
    end
  end
endmodule
